[rtl/core/indexed_list_store_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store
// Concurrent assertion helpers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ILS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`else
`define ILS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)
`endif
`endif

[rtl/core/ils_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list store package
// Field widths, operation and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 12;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ     = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_INS_TAIL = 3'd2,
    KIND_INS_POS  = 3'd3,
    KIND_DELETE   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE        = 3'd0,
    OP_READ        = 3'd1,
    OP_INS_PUT     = 3'd2,
    OP_INS_SHIFT   = 3'd3,
    OP_DEL_SHIFT   = 3'd4,
    OP_DEL_NOSHIFT = 3'd5
  } op_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic flush;
    logic put;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  dec_op;
    op_t  op;
    logic shift_last;
  } stat_t;

endpackage

[rtl/core/ils_if.sv]
// ----------------------------------------------------------------------------
// Indexed list store channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface ils_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ils_pkg::KIND_W-1:0]    kind;
  logic signed [ils_pkg::POS_W-1:0]     position;
  logic signed [ils_pkg::DATA_W-1:0]    value;

  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

interface ils_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ils_pkg::DATA_W-1:0]    read_data;
  logic        [ils_pkg::STATUS_W-1:0]  status;
  logic        [ils_pkg::LEN_W-1:0]     length;

  modport source (output valid, read_data, status, length, input ready);
  modport sink (input valid, read_data, status, length, output ready);
endinterface

[rtl/core/ils_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences accept, entry shifting, value write and result delivery.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ils_pkg::stat_t  stat,
  output ils_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_FLUSH = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (stat.dec_op)
            ils_pkg::OP_INS_PUT:   state_nxt = S_PUT;
            ils_pkg::OP_INS_SHIFT: state_nxt = S_SHIFT;
            ils_pkg::OP_DEL_SHIFT: state_nxt = S_SHIFT;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = (stat.op == ils_pkg::OP_INS_SHIFT) ? S_PUT : S_DONE;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/ils_dp.sv]
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Entry memory, length counter, operation decode and result registers.
// ----------------------------------------------------------------------------
module ils_dp #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ils_pkg::cmd_t                       cmd,
  output ils_pkg::stat_t                      stat,
  input  logic        [ils_pkg::KIND_W-1:0]   in_kind,
  input  logic signed [ils_pkg::POS_W-1:0]    in_position,
  input  logic signed [ils_pkg::DATA_W-1:0]   in_value,
  output logic signed [ils_pkg::DATA_W-1:0]   out_read_data,
  output logic        [ils_pkg::STATUS_W-1:0] out_status,
  output logic        [ils_pkg::LEN_W-1:0]    out_length
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PMAGW = ils_pkg::POS_W - 1;
  localparam int CMPW  = ((CW > PMAGW) ? CW : PMAGW) + 1;
  localparam logic [CW-1:0] CAP_CNT = CAPACITY[CW-1:0];

  logic [ils_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [ils_pkg::DATA_W-1:0] q_r;
  logic [ils_pkg::DATA_W-1:0] val_r;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             pend_r;
  ils_pkg::op_t     op_r;
  ils_pkg::status_t status_r;
  logic             miss_r;
  logic [AW-1:0]    at_r;
  logic [AW-1:0]    ptr_r;
  logic [AW-1:0]    wa_r;

  logic             pos_neg;
  logic [CMPW-1:0]  pv;
  logic [CMPW-1:0]  cv;
  logic [CMPW-1:0]  at_v;
  logic             ins;
  ils_pkg::op_t     dec_op;
  ils_pkg::status_t dec_status;
  logic             dec_miss;

  logic                       mem_re;
  logic                       mem_we;
  logic [AW-1:0]              mem_ra;
  logic [AW-1:0]              mem_wa;
  logic [ils_pkg::DATA_W-1:0] mem_wd;
  logic                       ins_run;
  logic [AW-1:0]              last_idx;

  always_comb begin
    pos_neg    = in_position[ils_pkg::POS_W-1];
    pv         = CMPW'(in_position[PMAGW-1:0]);
    cv         = CMPW'(count_r);
    at_v       = '0;
    ins        = 1'b0;
    dec_op     = ils_pkg::OP_NONE;
    dec_status = ils_pkg::ST_DONE;
    dec_miss   = 1'b0;
    case (in_kind)
      ils_pkg::KIND_READ: begin
        if (!pos_neg && (pv < cv)) begin
          dec_op = ils_pkg::OP_READ;
        end else begin
          dec_status = ils_pkg::ST_RANGE;
          dec_miss   = 1'b1;
        end
      end
      ils_pkg::KIND_INS_HEAD: begin
        ins = 1'b1;
      end
      ils_pkg::KIND_INS_TAIL: begin
        ins  = 1'b1;
        at_v = cv;
      end
      ils_pkg::KIND_INS_POS: begin
        if (!pos_neg && (pv > cv)) begin
          dec_status = ils_pkg::ST_RANGE;
        end else begin
          ins  = 1'b1;
          at_v = pos_neg ? '0 : pv;
        end
      end
      ils_pkg::KIND_DELETE: begin
        if (!pos_neg && (pv < cv)) begin
          dec_op = (pv == cv - CMPW'(1)) ? ils_pkg::OP_DEL_NOSHIFT : ils_pkg::OP_DEL_SHIFT;
        end else begin
          dec_status = ils_pkg::ST_RANGE;
        end
      end
      default: begin
        dec_status = ils_pkg::ST_RANGE;
      end
    endcase
    if (ins) begin
      if (count_r == CAP_CNT) begin
        dec_status = ils_pkg::ST_FULL;
      end else if (at_v == cv) begin
        dec_op = ils_pkg::OP_INS_PUT;
      end else begin
        dec_op = ils_pkg::OP_INS_SHIFT;
      end
    end
  end

  assign ins_run  = (op_r == ils_pkg::OP_INS_SHIFT);
  assign last_idx = AW'(count_r - CW'(1));

  assign stat.dec_op     = dec_op;
  assign stat.op         = op_r;
  assign stat.shift_last = ins_run ? (ptr_r == at_r) : (ptr_r == last_idx);

  assign mem_re = (cmd.load && (dec_op == ils_pkg::OP_READ)) || cmd.shift;
  assign mem_ra = cmd.shift ? ptr_r : AW'(pv);
  assign mem_we = (cmd.shift && pend_r) || cmd.flush || cmd.put;
  assign mem_wa = cmd.put ? at_r : wa_r;
  assign mem_wd = cmd.put ? val_r : q_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      q_r <= mem[mem_ra];
    end
  end

  always_comb begin
    case (op_r)
      ils_pkg::OP_INS_PUT:     count_nxt = count_r + CW'(1);
      ils_pkg::OP_INS_SHIFT:   count_nxt = count_r + CW'(1);
      ils_pkg::OP_DEL_SHIFT:   count_nxt = count_r - CW'(1);
      ils_pkg::OP_DEL_NOSHIFT: count_nxt = count_r - CW'(1);
      default:                 count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cmd.shift;
      if (cmd.emit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= dec_op;
      status_r <= dec_status;
      miss_r   <= dec_miss;
      val_r    <= in_value;
      at_r     <= AW'(at_v);
      ptr_r    <= (dec_op == ils_pkg::OP_INS_SHIFT) ? last_idx : AW'(pv + CMPW'(1));
    end
    if (cmd.shift) begin
      wa_r  <= ins_run ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
      ptr_r <= ins_run ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
    if (cmd.emit) begin
      out_status <= status_r;
      out_length <= ils_pkg::LEN_W'(count_nxt);
      if (op_r == ils_pkg::OP_READ) begin
        out_read_data <= q_r;
      end else if (miss_r) begin
        out_read_data <= '1;
      end else begin
        out_read_data <= '0;
      end
    end
  end

endmodule

[rtl/core/indexed_list_store_top.sv]
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list of signed 32-bit values with indexed read, insert and delete.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result beat. A read, a rejected
// item or a delete of the last entry goes straight to its result; an insert
// at the tail writes the value, then gives its result; an insert before
// position p moves the entries from the last down to p up one place, writes
// the last moved entry and the value, then gives its result; a delete at any
// other position p moves the entries after p down one place and writes the
// last moved entry, then gives its result. The longest item is an insert at
// the head of a list one entry short of full. The memory moves one entry per
// cycle through its single read port and single write port. A finished
// result waits in the output register while the next item is taken and
// worked on; the block holds in its done state only when that next item is
// done before the earlier beat is taken. The memory is not cleared on reset.
`include "indexed_list_store_top_assert.svh"

module indexed_list_store_top #(
  parameter int CAPACITY = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  ils_in_if.sink     in_ch,
  ils_out_if.source  out_ch
);

  localparam logic [ils_pkg::LEN_W-1:0] CAP_LEN = CAPACITY[ils_pkg::LEN_W-1:0];

  ils_pkg::cmd_t  cmd;
  ils_pkg::stat_t stat;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ils_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_ch.kind),
    .in_position   (in_ch.position),
    .in_value      (in_ch.value),
    .out_read_data (out_ch.read_data),
    .out_status    (out_ch.status),
    .out_length    (out_ch.length)
  );

  `ILS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
                   in_ch.valid && in_ch.ready, !in_ch.ready,
                   "item accepted while previous item still in work")
  `ILS_ASSERT_ALWAYS(a_emit_when_free, clk, rst_n,
                     !cmd.emit || !out_ch.valid || out_ch.ready,
                     "result overwrote an undelivered beat")
  `ILS_ASSERT_ALWAYS(a_full_length, clk, rst_n,
                     !(out_ch.valid && (out_ch.status == ils_pkg::ST_FULL)) ||
                     (out_ch.length == CAP_LEN),
                     "full status with list below capacity")

endmodule
